// ----- design/servo_bus_packet_responder_unit_macros.svh -----
// Assertion macros shared by the servo bus responder modules.
`ifndef SERVO_BUS_PACKET_RESPONDER_UNIT_MACROS_SVH
`define SERVO_BUS_PACKET_RESPONDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbpr assertion failed");

// Next-cycle implication, checked outside reset.
`define SBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbpr assertion failed");

`endif

// ----- design/sbpr_pkg.sv -----
// Package: types, codes and constants of the servo bus packet responder.
`default_nettype none
package sbpr_pkg;

    localparam int PARAM_DEPTH_DEF = 2;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [7:0] PREAMBLE     = 8'hFF;
    localparam logic [7:0] ID_LIMIT     = 8'd254;
    localparam logic [7:0] LEN_LIMIT    = 8'd100;
    localparam logic [7:0] INSTR_LIMIT  = 8'h07;
    localparam logic [7:0] INSTR_BULK   = 8'h83;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] REG_ENCODER  = 8'h25;
    localparam logic [7:0] REG_ACCEL    = 8'h2B;
    localparam logic [7:0] REG_LED      = 8'h19;
    localparam logic [7:0] INS_PING     = 8'h01;
    localparam logic [7:0] INS_READ     = 8'h02;
    localparam logic [7:0] INS_WRITE    = 8'h03;
    localparam logic [7:0] LEN_ENCODER  = 8'd2;
    localparam logic [7:0] LEN_ACCEL    = 8'd8;
    localparam logic [6:0] LEN_WRITE    = 7'd4;
    localparam logic [6:0] COUNT_MAX    = 7'd127;
    localparam logic [7:0] DEVICE_ID_RESET = 8'd12;

    typedef enum logic [2:0] {
        PS_PRE1, PS_PRE2, PS_ID, PS_LEN, PS_INSTR, PS_PARAM, PS_CSUM
    } t_parse_state;

    typedef enum logic [1:0] {
        RK_NONE, RK_PING, RK_ENC, RK_ACC
    } t_reply_kind;

    typedef struct packed {
        t_reply_kind kind;
        logic        led;
        logic [63:0] data;
    } t_cmd;

endpackage
`default_nettype wire

// ----- design/sbpr_front.sv -----
// Front end: packet parser that classifies each received byte into a reply command.
`default_nettype none
`include "servo_bus_packet_responder_unit_macros.svh"
module sbpr_front #(
    parameter int PARAM_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [15:0]   i_encoder_value,
    input  wire logic [63:0]   i_accel_data,
    input  wire logic [7:0]    i_device_id,
    output logic               o_push,
    output sbpr_pkg::t_cmd     o_cmd
);
    import sbpr_pkg::*;

    localparam int IDX_W = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;

    t_parse_state r_state, n_state;
    logic [7:0] r_id, n_id;
    logic [6:0] r_len, n_len;
    logic [7:0] r_ins, n_ins;
    logic [7:0] r_sum, n_sum;
    logic [6:0] r_cnt, n_cnt;
    logic [7:0] r_param [PARAM_DEPTH];
    logic [7:0] n_param [PARAM_DEPTH];
    logic       r_led, n_led;

    logic        id_ok, len_ok, ins_ok, store_ok, param_done, pkt_ok;
    logic [6:0]  cnt_inc;
    logic [IDX_W-1:0] store_idx;
    t_reply_kind kind;

    assign id_ok      = i_rx_byte < ID_LIMIT;
    assign len_ok     = i_rx_byte < LEN_LIMIT;
    assign ins_ok     = (i_rx_byte < INSTR_LIMIT) || (i_rx_byte == INSTR_BULK);
    assign cnt_inc    = (r_cnt < COUNT_MAX) ? r_cnt + 7'd1 : r_cnt;
    assign param_done = ({1'b0, cnt_inc} + 8'd2) >= {1'b0, r_len};
    assign store_ok   = r_cnt < 7'(PARAM_DEPTH);
    assign store_idx  = r_cnt[IDX_W-1:0];
    assign pkt_ok     = (i_rx_byte == ~r_sum)
                        && ((r_id == i_device_id) || (r_id == BROADCAST_ID));

    always_comb begin
        unique case (r_state)
            PS_PRE1:  n_state = (i_rx_byte == PREAMBLE) ? PS_PRE2 : PS_PRE1;
            PS_PRE2:  n_state = (i_rx_byte == PREAMBLE) ? PS_ID : PS_PRE1;
            PS_ID:    n_state = id_ok ? PS_LEN : PS_PRE1;
            PS_LEN:   n_state = len_ok ? PS_INSTR : PS_PRE1;
            PS_INSTR: begin
                if (!ins_ok) n_state = PS_PRE1;
                else         n_state = (r_len > 7'd2) ? PS_PARAM : PS_CSUM;
            end
            PS_PARAM: n_state = param_done ? PS_CSUM : PS_PARAM;
            PS_CSUM:  n_state = PS_PRE1;
            default:  n_state = PS_PRE1;
        endcase
    end

    always_comb begin
        n_id    = r_id;
        n_len   = r_len;
        n_ins   = r_ins;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_param = r_param;
        n_led   = r_led;
        kind    = RK_NONE;
        unique case (r_state)
            PS_ID: begin
                if (id_ok) begin
                    n_id  = i_rx_byte;
                    n_sum = i_rx_byte;
                end
            end
            PS_LEN: begin
                if (len_ok) begin
                    n_len = i_rx_byte[6:0];
                    n_sum = r_sum + i_rx_byte;
                end
            end
            PS_INSTR: begin
                if (ins_ok) begin
                    n_ins = i_rx_byte;
                    n_sum = r_sum + i_rx_byte;
                    n_cnt = 7'd0;
                end
            end
            PS_PARAM: begin
                n_sum = r_sum + i_rx_byte;
                if (store_ok) n_param[store_idx] = i_rx_byte;
                n_cnt = cnt_inc;
            end
            PS_CSUM: begin
                if (pkt_ok) begin
                    if (r_ins == INS_PING) begin
                        kind = RK_PING;
                    end else if (r_ins == INS_READ) begin
                        if (r_param[0] == REG_ENCODER && r_param[1] == LEN_ENCODER)
                            kind = RK_ENC;
                        else if (r_param[0] == REG_ACCEL && r_param[1] == LEN_ACCEL)
                            kind = RK_ACC;
                    end else if (r_ins == INS_WRITE) begin
                        if (r_len == LEN_WRITE && r_param[0] == REG_LED)
                            n_led = (r_param[1] != 8'd0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_PRE1;
            r_id    <= '0;
            r_len   <= '0;
            r_ins   <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_led   <= 1'b0;
            for (int i = 0; i < PARAM_DEPTH; i++) r_param[i] <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_id    <= n_id;
            r_len   <= n_len;
            r_ins   <= n_ins;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_led   <= n_led;
            r_param <= n_param;
        end
    end

    assign o_push     = i_accept;
    assign o_cmd.kind = kind;
    assign o_cmd.led  = n_led;
    assign o_cmd.data = (kind == RK_ACC) ? i_accel_data : {48'd0, i_encoder_value};

    `SBPR_ASSERT_IMPL(a_param_needs_len, i_clk, i_rst_n, r_state == PS_PARAM, r_len > 7'd2)

endmodule
`default_nettype wire

// ----- design/sbpr_cmd_fifo.sv -----
// Short command queue between parser and reply sequencer.
`default_nettype none
`include "servo_bus_packet_responder_unit_macros.svh"
module sbpr_cmd_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire sbpr_pkg::t_cmd i_cmd,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sbpr_pkg::t_cmd o_head
);
    import sbpr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = r_count == CNT_W'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    `SBPR_ASSERT_IMPL(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `SBPR_ASSERT_IMPL(a_fifo_no_underrun, i_clk, i_rst_n, i_pop, !o_empty)

endmodule
`default_nettype wire

// ----- design/sbpr_back.sv -----
// Back end: sequences status reply bytes from queued commands into the output register.
`default_nettype none
`include "servo_bus_packet_responder_unit_macros.svh"
module sbpr_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_empty,
    input  wire sbpr_pkg::t_cmd i_head,
    output logic           o_pop,
    input  wire logic [7:0] i_device_id,
    output logic           o_valid,
    input  wire logic      i_stall,
    output logic           o_tx_valid,
    output logic [7:0]     o_tx_byte,
    output logic           o_last,
    output logic           o_led_on
);
    import sbpr_pkg::*;

    logic [3:0] r_idx, n_idx;
    logic [7:0] r_sum, n_sum;
    logic       r_valid, n_valid;
    logic       r_tx_valid, r_last, r_led;
    logic [7:0] r_byte;

    logic [3:0] data_n, last_idx;
    logic [2:0] d_idx;
    logic [7:0] byte_sel;
    logic       can_load, load, byte_last, is_reply;

    always_comb begin
        case (i_head.kind)
            RK_ENC:  data_n = 4'd2;
            RK_ACC:  data_n = 4'd8;
            default: data_n = 4'd0;
        endcase
    end

    assign is_reply  = i_head.kind != RK_NONE;
    assign last_idx  = 4'd5 + data_n;
    assign d_idx     = 3'(r_idx - 4'd5);
    assign byte_last = !is_reply || (r_idx == last_idx);
    assign can_load  = !r_valid || !i_stall;
    assign load      = !i_empty && can_load;
    assign o_pop     = load && byte_last;

    always_comb begin
        case (r_idx)
            4'd0, 4'd1: byte_sel = PREAMBLE;
            4'd2:       byte_sel = i_device_id;
            4'd3:       byte_sel = 8'd2 + {4'd0, data_n};
            4'd4:       byte_sel = 8'd0;
            default: begin
                if (r_idx == last_idx) byte_sel = ~r_sum;
                else                   byte_sel = i_head.data[{d_idx, 3'b000} +: 8];
            end
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_valid = r_valid && i_stall;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = byte_last ? 4'd0 : r_idx + 4'd1;
            n_sum   = (r_idx == 4'd2) ? byte_sel : r_sum + byte_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_valid <= is_reply;
            r_byte     <= is_reply ? byte_sel : 8'd0;
            r_last     <= byte_last;
            r_led      <= i_head.led;
        end
    end

    assign o_valid    = r_valid;
    assign o_tx_valid = r_tx_valid;
    assign o_tx_byte  = r_byte;
    assign o_last     = r_last;
    assign o_led_on   = r_led;

    `SBPR_ASSERT_IMPL(a_mid_reply_has_cmd, i_clk, i_rst_n, r_idx != 4'd0, !i_empty)
    `SBPR_ASSERT_IMPL(a_no_reply_is_last, i_clk, i_rst_n, r_valid && !r_tx_valid, r_last)

endmodule
`default_nettype wire

// ----- design/servo_bus_packet_responder_unit.sv -----
// Top level of the servo bus packet responder: parser, command queue and reply sequencer.
`default_nettype none
// Each received bus byte is one input item; the parser pushes one command per byte into
// a two-entry queue, and the reply sequencer drains it one output item per cycle unless
// the receiver stalls: one item for a byte that causes no reply, 6 to 14 items (one per
// status packet byte) for a byte that completes a ping or an encoder or accelerometer
// read. Sustained rate is one input byte per cycle when no replies are due and there is
// no receiver stall; input stalls only while the queue is full. The user must write
// device_id through the configuration port only while idle; the block does not check it.
module servo_bus_packet_responder_unit #(
    parameter int PARAM_DEPTH = sbpr_pkg::PARAM_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [15:0] i_encoder_value,
    input  wire logic [63:0] i_accel_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_last,
    output logic             o_led_on
);
    import sbpr_pkg::*;

    logic [7:0] r_device_id;
    logic       accept, push, pop, full, empty;
    t_cmd       push_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_device_id <= DEVICE_ID_RESET;
        else if (i_cfg_wr_en) r_device_id <= i_cfg_wr_data;
    end

    assign o_stall = full;
    assign accept  = i_valid && !full;

    sbpr_front #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_rx_byte       (i_rx_byte),
        .i_encoder_value (i_encoder_value),
        .i_accel_data    (i_accel_data),
        .i_device_id     (r_device_id),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    sbpr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    sbpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .i_device_id (r_device_id),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last),
        .o_led_on    (o_led_on)
    );

endmodule
`default_nettype wire

// ----- tb/servo_bus_packet_responder_unit_tb.sv -----
// Servo bus packet responder testbench: directed and random traffic, checked by a byte-level parser model.
`timescale 1ns / 1ps
module servo_bus_packet_responder_unit_tb;
    import sbpr_pkg::*;

    localparam int PDEPTH        = PARAM_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_MAX  = 2000;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       led_on;
    } t_tx_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic [15:0] i_encoder_value = 16'h0000;
    logic [63:0] i_accel_data = 64'h0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic        o_led_on;

    servo_bus_packet_responder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_encoder_value (i_encoder_value),
        .i_accel_data    (i_accel_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_led_on        (o_led_on)
    );

    always #4 i_clk = ~i_clk;

    // parser model state
    t_parse_state parse_st = PS_PRE1;
    logic [7:0]   model_dev_id = DEVICE_ID_RESET;
    logic [7:0]   model_pkt_id = 8'h00;
    logic [6:0]   model_pkt_len = 7'd0;
    logic [7:0]   model_instr = 8'h00;
    logic [7:0]   model_sum = 8'h00;
    logic [6:0]   model_count = 7'd0;
    logic [7:0]   model_params [PDEPTH];
    logic         model_led = 1'b0;

    t_tx_beat     reply_beats_q [$];
    logic [7:0]   param_bytes [$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           bytes_sent = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    initial begin
        for (int i = 0; i < PDEPTH; i++) model_params[i] = 8'h00;
    end

    task automatic push_status_reply(input logic [7:0] payload [8], input int n);
        logic [7:0] pkt [$];
        logic [7:0] sum;
        sum = 8'h00;
        pkt.push_back(PREAMBLE);
        pkt.push_back(PREAMBLE);
        pkt.push_back(model_dev_id);
        pkt.push_back(8'(2 + n));
        pkt.push_back(8'h00);
        for (int i = 0; i < n; i++) pkt.push_back(payload[i]);
        for (int i = 2; i < pkt.size(); i++) sum = sum + pkt[i];
        pkt.push_back(~sum);
        foreach (pkt[i]) reply_beats_q.push_back('{1'b1, pkt[i], i == pkt.size() - 1, model_led});
    endtask

    task automatic predict_bus_byte(input logic [7:0] b, input logic [15:0] enc,
                                    input logic [63:0] acc);
        logic [7:0] payload [8];
        bit         reply;
        int         n;
        reply = 1'b0;
        n = 0;
        for (int i = 0; i < 8; i++) payload[i] = 8'h00;
        case (parse_st)
            PS_PRE1: if (b == PREAMBLE) parse_st = PS_PRE2;
            PS_PRE2: parse_st = (b == PREAMBLE) ? PS_ID : PS_PRE1;
            PS_ID: begin
                if (b < ID_LIMIT) begin
                    model_pkt_id = b;
                    model_sum = b;
                    parse_st = PS_LEN;
                end else begin
                    parse_st = PS_PRE1;
                end
            end
            PS_LEN: begin
                if (b < LEN_LIMIT) begin
                    model_pkt_len = b[6:0];
                    model_sum = model_sum + b;
                    parse_st = PS_INSTR;
                end else begin
                    parse_st = PS_PRE1;
                end
            end
            PS_INSTR: begin
                if (b < INSTR_LIMIT || b == INSTR_BULK) begin
                    model_instr = b;
                    model_sum = model_sum + b;
                    model_count = 7'd0;
                    parse_st = (model_pkt_len > 7'd2) ? PS_PARAM : PS_CSUM;
                end else begin
                    parse_st = PS_PRE1;
                end
            end
            PS_PARAM: begin
                model_sum = model_sum + b;
                if (int'(model_count) < PDEPTH) model_params[model_count] = b;
                if (model_count < COUNT_MAX) model_count = model_count + 7'd1;
                if (int'(model_count) + 2 >= int'(model_pkt_len)) parse_st = PS_CSUM;
            end
            PS_CSUM: begin
                parse_st = PS_PRE1;
                if (b == ~model_sum &&
                    (model_pkt_id == model_dev_id || model_pkt_id == BROADCAST_ID)) begin
                    if (model_instr == INS_PING) begin
                        reply = 1'b1;
                    end else if (model_instr == INS_READ) begin
                        if (model_params[0] == REG_ENCODER && model_params[1] == LEN_ENCODER) begin
                            reply = 1'b1;
                            n = 2;
                            payload[0] = enc[7:0];
                            payload[1] = enc[15:8];
                        end else if (model_params[0] == REG_ACCEL &&
                                     model_params[1] == LEN_ACCEL) begin
                            reply = 1'b1;
                            n = 8;
                            for (int i = 0; i < 8; i++) payload[i] = acc[8*i +: 8];
                        end
                    end else if (model_instr == INS_WRITE) begin
                        if (model_pkt_len == LEN_WRITE && model_params[0] == REG_LED)
                            model_led = (model_params[1] != 8'h00);
                    end
                end
            end
            default: parse_st = PS_PRE1;
        endcase
        if (reply)
            push_status_reply(payload, n);
        else
            reply_beats_q.push_back('{1'b0, 8'h00, 1'b1, model_led});
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_tx_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_beats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tx item with nothing pending: valid=%0d byte=%02h last=%0d led=%0d",
                             o_tx_valid, o_tx_byte, o_last, o_led_on);
            end else begin
                want = reply_beats_q.pop_front();
                if (o_tx_valid !== want.tx_valid || o_tx_byte !== want.tx_byte ||
                    o_last !== want.last || o_led_on !== want.led_on) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tx item differs: want valid=%0d byte=%02h last=%0d led=%0d, got valid=%0d byte=%02h last=%0d led=%0d",
                                 want.tx_valid, want.tx_byte, want.last, want.led_on,
                                 o_tx_valid, o_tx_byte, o_last, o_led_on);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("servo_bus_packet_responder_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_bus_byte(input logic [7:0] b);
        logic [15:0] enc;
        logic [63:0] acc;
        case ($urandom_range(9))
            0:       enc = 16'h0000;
            1:       enc = 16'hFFFF;
            default: enc = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       acc = 64'h0;
            1:       acc = '1;
            default: acc = {$urandom, $urandom};
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        i_encoder_value <= enc;
        i_accel_data <= acc;
        do @(posedge i_clk); while (o_stall);
        predict_bus_byte(b, enc, acc);
        bytes_sent++;
    endtask

    task automatic wait_for_replies();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (reply_beats_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_device_id(input logic [7:0] id);
        wait_for_replies();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= id;
        @(posedge i_clk);
        model_dev_id = id;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // framed packet carrying param_bytes; the length field is given by the caller
    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] instr, input bit bad_sum);
        logic [7:0] sum;
        sum = id + len + instr;
        foreach (param_bytes[i]) sum = sum + param_bytes[i];
        send_bus_byte(PREAMBLE);
        send_bus_byte(PREAMBLE);
        send_bus_byte(id);
        send_bus_byte(len);
        send_bus_byte(instr);
        foreach (param_bytes[i]) send_bus_byte(param_bytes[i]);
        send_bus_byte(bad_sum ? ~sum ^ 8'($urandom_range(1, 255)) : ~sum);
    endtask

    function automatic logic [7:0] pick_target_id();
        int r;
        r = $urandom_range(99);
        if (r < 70) return model_dev_id;
        if (r < 85) return BROADCAST_ID;
        return 8'($urandom_range(0, 253));
    endfunction

    function automatic logic [7:0] pick_instr();
        int r;
        r = $urandom_range(7);
        return (r == 7) ? INSTR_BULK : 8'(r);
    endfunction

    task automatic send_broken_sequence();
        logic [7:0] b;
        case ($urandom_range(3))
            0: repeat ($urandom_range(1, 6)) send_bus_byte(8'($urandom));
            1: begin
                send_bus_byte(PREAMBLE);
                send_bus_byte(PREAMBLE);
                send_bus_byte(8'($urandom_range(254, 255)));
            end
            2: begin
                send_bus_byte(PREAMBLE);
                send_bus_byte(PREAMBLE);
                send_bus_byte(pick_target_id());
                send_bus_byte(8'($urandom_range(100, 255)));
            end
            default: begin
                do b = 8'($urandom_range(7, 255)); while (b == INSTR_BULK);
                send_bus_byte(PREAMBLE);
                send_bus_byte(PREAMBLE);
                send_bus_byte(pick_target_id());
                send_bus_byte(8'd2);
                send_bus_byte(b);
            end
        endcase
    endtask

    task automatic test_directed_packets();
        // stray bytes and a broken preamble
        send_bus_byte(8'h00);
        send_bus_byte(PREAMBLE);
        send_bus_byte(8'h55);
        // broadcast ping
        param_bytes.delete();
        send_frame(BROADCAST_ID, 8'd2, INS_PING, 1'b0);
        // encoder read at the reset device id
        param_bytes.delete();
        param_bytes.push_back(REG_ENCODER);
        param_bytes.push_back(LEN_ENCODER);
        send_frame(DEVICE_ID_RESET, 8'd4, INS_READ, 1'b0);
        // LED on with only the top bit set
        param_bytes.delete();
        param_bytes.push_back(REG_LED);
        param_bytes.push_back(8'h80);
        send_frame(DEVICE_ID_RESET, 8'd4, INS_WRITE, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int         stop_at;
        int         kind;
        int         nparam;
        logic [7:0] id;
        logic [7:0] instr;
        logic [7:0] len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            id = pick_target_id();
            instr = INS_PING;
            param_bytes.delete();
            if (kind < 18) begin
                instr = INS_PING;
            end else if (kind < 32) begin
                instr = INS_READ;
                param_bytes.push_back(REG_ENCODER);
                param_bytes.push_back(LEN_ENCODER);
            end else if (kind < 45) begin
                instr = INS_READ;
                param_bytes.push_back(REG_ACCEL);
                param_bytes.push_back(LEN_ACCEL);
            end else if (kind < 58) begin
                instr = INS_WRITE;
                param_bytes.push_back(REG_LED);
                param_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255)));
            end else if (kind < 70) begin
                instr = pick_instr();
                nparam = $urandom_range(0, 5);
                repeat (nparam) param_bytes.push_back(8'($urandom));
                if (nparam >= 2 && $urandom_range(1))
                    param_bytes[0] = ($urandom_range(1)) ? REG_ENCODER : REG_ACCEL;
            end else if (kind < 77) begin
                // long parameter list, occasionally the longest length allowed
                instr = $urandom_range(1) ? INS_READ : pick_instr();
                nparam = ($urandom_range(9) == 0) ? 97 : $urandom_range(3, 12);
                param_bytes.push_back(($urandom_range(1)) ? REG_ENCODER : REG_ACCEL);
                param_bytes.push_back(($urandom_range(1)) ? LEN_ENCODER : LEN_ACCEL);
                repeat (nparam - 2) param_bytes.push_back(8'($urandom));
            end else if (kind < 84) begin
                // too few parameters: stale stored bytes are used
                instr = $urandom_range(1) ? INS_READ : INS_WRITE;
                if ($urandom_range(1)) param_bytes.push_back(8'($urandom));
            end
            if (kind < 84) begin
                len = 8'(param_bytes.size() + 2);
                if (param_bytes.size() == 0 && $urandom_range(2) == 0)
                    len = 8'($urandom_range(0, 1));
                send_frame(id, len, instr, $urandom_range(9) == 0);
            end else begin
                send_broken_sequence();
            end
        end
    endtask

    task automatic test_drained_pause();
        param_bytes.delete();
        param_bytes.push_back(REG_ACCEL);
        param_bytes.push_back(LEN_ACCEL);
        send_frame(model_dev_id, 8'd4, INS_READ, 1'b0);
        wait_for_replies();
        param_bytes.delete();
        send_frame(model_dev_id, 8'd2, INS_PING, 1'b0);
    endtask

    task automatic test_device_id(input logic [7:0] id, input int n_bytes);
        write_device_id(id);
        test_random_traffic(n_bytes);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 85;
        test_directed_packets();
        test_random_traffic(30);
        test_drained_pause();
        test_device_id(8'd0, 30);

        send_idle_pct = 85;
        recv_idle_pct = 16;
        test_device_id(8'd253, 40);
        test_device_id(8'd254, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_device_id(8'd255, 20);
        test_device_id(8'($urandom_range(1, 252)), 40);

        wait_for_replies();
        if (mismatches == 0)
            $display("servo_bus_packet_responder_unit: match");
        else
            $display("servo_bus_packet_responder_unit: mismatch");
        $finish;
    end

endmodule

// ----- servo_bus_packet_responder_unit.f -----
+incdir+design
design/sbpr_pkg.sv
design/sbpr_front.sv
design/sbpr_cmd_fifo.sv
design/sbpr_back.sv
design/servo_bus_packet_responder_unit.sv
tb/servo_bus_packet_responder_unit_tb.sv
